// ----- hw/rtl/drs_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and operation codes for the block-decomposed range sum core.
package drs_pkg;

    localparam int ELEMENT_COUNT = 1024;
    localparam int BLOCK_LENGTH  = 32;
    localparam int BLOCK_COUNT   = (ELEMENT_COUNT + BLOCK_LENGTH - 1) / BLOCK_LENGTH;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;

    localparam int ELEM_AW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
    localparam int BLK_AW  = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int POS_W   = ELEM_AW + 1;

    typedef enum logic [OP_W-1:0] {
        OP_SET = 2'd0,
        OP_ADD = 2'd1,
        OP_SUM = 2'd2,
        OP_NOP = 2'd3
    } op_t;

endpackage

// ----- hw/rtl/drs_intf.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and range sum responses.
interface drs_req_if;
    logic                               valid;
    logic                               ready;
    logic [drs_pkg::OP_W-1:0]           operation;
    logic [drs_pkg::IDX_W-1:0]          first_index;
    logic [drs_pkg::IDX_W-1:0]          last_index;
    logic signed [drs_pkg::DATA_W-1:0]  value;

    modport source (output valid, output operation, output first_index,
                    output last_index, output value, input ready);
    modport sink   (input valid, input operation, input first_index,
                    input last_index, input value, output ready);
endinterface

interface drs_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [drs_pkg::DATA_W-1:0]  range_sum;

    modport source (output valid, output range_sum, input ready);
    modport sink   (input valid, input range_sum, output ready);
endinterface

// ----- hw/rtl/drs_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module drs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// ----- hw/rtl/block_decomposed_range_sum_core.sv -----
`timescale 1ns / 1ps
// Top level of the block-decomposed range sum core: sequencer around two RAMs.
// Steps: a set or add reads on acceptance and writes back in the update state; a sum
// makes R RAM reads, R being the partial-block elements plus the whole blocks covered,
// at most 92, then finishes; an empty range goes straight to the finish. A finished sum
// also waits while the last result is unaccepted. Throughput: one item at a time; the
// single read port of each RAM sets the pace. Reset: after rst_n releases, a clearing
// pass zeroes both RAMs, during which no request transfer is accepted.
module block_decomposed_range_sum_core (
    input  logic      clk,
    input  logic      rst_n,
    drs_req_if.sink   req,
    drs_rsp_if.source rsp
);
    import drs_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_UPD   = 5'b00100,
        ST_SUM   = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Clearing pass address.
    logic [ELEM_AW-1:0] clr_cnt_reg, clr_cnt_next;

    // Item context. pos_reg holds the element index for set/add and the
    // walking position for a sum; it has one spare bit so that stepping a
    // whole block past the end cannot wrap.
    op_t                op_reg, op_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [ELEM_AW-1:0] last_reg, last_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [DATA_W-1:0]  acc_reg, acc_next;

    // A RAM read was issued last cycle and its data is now on rdata.
    logic pend_reg, pend_next;
    logic pend_blk_reg, pend_blk_next;

    // Response output register.
    logic              rsp_valid_reg, rsp_valid_next;
    logic [DATA_W-1:0] rsp_sum_reg, rsp_sum_next;

    // RAM ports.
    logic               elem_we, blk_we;
    logic [ELEM_AW-1:0] elem_waddr, elem_raddr;
    logic [BLK_AW-1:0]  blk_waddr, blk_raddr;
    logic [DATA_W-1:0]  elem_wdata, blk_wdata, elem_rdata, blk_rdata;

    // Decoded request fields.
    logic               req_fire;
    logic               req_in_range;
    logic [ELEM_AW-1:0] req_last_clamped;
    logic               sum_nonempty;

    // Sum walk decisions.
    logic              walk_more;
    logic              walk_block;
    logic [DATA_W-1:0] walk_contrib;

    drs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ELEMENT_COUNT)
    ) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (elem_wdata),
        .raddr (elem_raddr),
        .rdata (elem_rdata)
    );

    drs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BLOCK_COUNT)
    ) u_blk_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .raddr (blk_raddr),
        .rdata (blk_rdata)
    );

    // The core takes a new request only when it is idle; a finished result
    // may still be waiting in the response register at that time.
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.range_sum = rsp_sum_reg;

    // An index at or beyond the array size makes set and add no-ops and an
    // empty sum. The end of a sum range is clamped to the last element.
    assign req_in_range     = (32'(req.first_index) < ELEMENT_COUNT);
    assign req_last_clamped = (32'(req.last_index) >= ELEMENT_COUNT)
                              ? ELEM_AW'(ELEMENT_COUNT - 1)
                              : ELEM_AW'(req.last_index);
    assign sum_nonempty     = req_in_range &&
                              (32'(req.first_index) <= 32'(req_last_clamped));

    // A whole block sum is taken when the walk sits on a block boundary and
    // the whole block lies inside the range; otherwise one element is taken.
    assign walk_more  = (32'(pos_reg) <= 32'(last_reg));
    assign walk_block = ((32'(pos_reg) % BLOCK_LENGTH) == 0) &&
                        (32'(last_reg) >= 32'(pos_reg) + BLOCK_LENGTH - 1);

    // Data for the read issued in the previous cycle.
    assign walk_contrib = pend_reg ? (pend_blk_reg ? blk_rdata : elem_rdata) : '0;

    // Read addresses: straight from the request on acceptance, so the old
    // element and block sum arrive in the update cycle; from the walk
    // position while summing.
    always_comb
    begin
        if (state_reg == ST_SUM)
        begin
            elem_raddr = ELEM_AW'(pos_reg);
            blk_raddr  = BLK_AW'(32'(pos_reg) / BLOCK_LENGTH);
        end
        else
        begin
            elem_raddr = ELEM_AW'(req.first_index);
            blk_raddr  = BLK_AW'(32'(req.first_index) / BLOCK_LENGTH);
        end
    end

    // Write ports: zero during the clearing pass, read-modify-write results in
    // the update cycle. A set moves the block sum by the difference between
    // the new and the old element.
    always_comb
    begin
        elem_we    = 1'b0;
        blk_we     = 1'b0;
        elem_waddr = ELEM_AW'(pos_reg);
        blk_waddr  = BLK_AW'(32'(pos_reg) / BLOCK_LENGTH);
        elem_wdata = '0;
        blk_wdata  = '0;
        if (state_reg == ST_CLEAR)
        begin
            elem_we    = 1'b1;
            blk_we     = (32'(clr_cnt_reg) < BLOCK_COUNT);
            elem_waddr = clr_cnt_reg;
            blk_waddr  = BLK_AW'(clr_cnt_reg);
        end
        else if (state_reg == ST_UPD)
        begin
            elem_we = 1'b1;
            blk_we  = 1'b1;
            if (op_reg == OP_SET)
            begin
                elem_wdata = val_reg;
                blk_wdata  = blk_rdata + val_reg - elem_rdata;
            end
            else
            begin
                elem_wdata = elem_rdata + val_reg;
                blk_wdata  = blk_rdata + val_reg;
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        val_next       = val_reg;
        acc_next       = acc_reg;
        pend_next      = 1'b0;
        pend_blk_next  = pend_blk_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_sum_next   = rsp_sum_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (32'(clr_cnt_reg) == ELEMENT_COUNT - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    op_next   = op_t'(req.operation);
                    pos_next  = POS_W'(req.first_index);
                    last_next = req_last_clamped;
                    val_next  = req.value;
                    acc_next  = '0;
                    case (op_t'(req.operation))
                        OP_SET, OP_ADD:
                        begin
                            if (req_in_range)
                            begin
                                state_next = ST_UPD;
                            end
                        end
                        OP_SUM:
                        begin
                            state_next = sum_nonempty ? ST_SUM : ST_FIN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_UPD:
            begin
                state_next = ST_IDLE;
            end
            ST_SUM:
            begin
                // One read is issued per cycle; its data is added in the next cycle.
                acc_next = acc_reg + walk_contrib;
                if (walk_more)
                begin
                    pend_next     = 1'b1;
                    pend_blk_next = walk_block;
                    pos_next      = walk_block ? pos_reg + POS_W'(BLOCK_LENGTH)
                                               : pos_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_sum_next   = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        last_reg     <= last_next;
        val_reg      <= val_next;
        acc_reg      <= acc_next;
        pend_blk_reg <= pend_blk_next;
        rsp_sum_reg  <= rsp_sum_next;
    end

    // A pending read only ever comes from the walk of a sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == ST_SUM))
        else $error("pending read without a sum walk");

    // The walk never steps past the element after the range end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (32'(pos_reg) <= 32'(last_reg) + 1))
        else $error("sum walk overran the range end");

    // A new result is loaded only when a sum finishes.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("response raised outside the finish state");

    // The RAMs are written only by the clearing pass or an update.
    assert property (@(posedge clk) disable iff (!rst_n)
        (elem_we || blk_we) |-> (state_reg == ST_CLEAR || state_reg == ST_UPD))
        else $error("RAM write outside clear or update");

    // An accepted in-range set or add is written back in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req_in_range &&
         (req.operation == OP_SET || req.operation == OP_ADD))
        |=> (state_reg == ST_UPD))
        else $error("update did not follow an accepted set or add");

endmodule
